// ----- rtl/hashed_key_max_table_core_defines.svh -----
// Assertion macros shared by the hashed key max table RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef HASHED_KEY_MAX_TABLE_CORE_DEFINES_SVH
`define HASHED_KEY_MAX_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define HKMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HKMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hkmt_pkg.sv -----
// Package for the hashed key max table: sizes, codes, hash constants and
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hkmt_pkg;

  localparam int SLOT_W  = 10;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int IDX_W   = 10;
  localparam int KEY_W   = 64;
  localparam int ENTRY_W = 1 + 2 * KEY_W;

  localparam logic [63:0] HASH_ADD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_K1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_K2  = 64'h94d049bb133111eb;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_NEW  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MIX30,
    DP_MIX27,
    DP_MUL,
    DP_HOME,
    DP_STEP,
    DP_RESOLVE,
    DP_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] mul_step;
    logic       mul_k2;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic probe_stop;
    logic probe_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/hkmt_if.sv -----
// Valid/ready channel interfaces for the hashed key max table.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface hkmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] lookup_key;
  logic [63:0] candidate_value;
  modport source (output valid, operation, lookup_key, candidate_value, input ready);
  modport sink (input valid, operation, lookup_key, candidate_value, output ready);
endinterface

interface hkmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] stored_max;
  logic [9:0]  slot_index;
  modport source (output valid, status, stored_max, slot_index, input ready);
  modport sink (input valid, status, stored_max, slot_index, output ready);
endinterface
`default_nettype wire

// ----- rtl/hkmt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hkmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/hkmt_ctrl.sv -----
// Controller for the hashed key max table: clear pass, hash sequencing,
// probe loop. Depends on hkmt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_key_max_table_core_defines.svh"
module hkmt_ctrl
  import hkmt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MIX30 = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MIX27 = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_HOME  = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    cmd_o.op        = DP_NOP;
    cmd_o.mul_step  = step_q;
    cmd_o.mul_k2    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_MIX30;
        end
      end
      S_MIX30: begin
        cmd_o.op = DP_MIX30;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = DP_MUL;
        step_d   = step_q + 2'd1;
        if (step_q == 2'd3) state_d = S_MIX27;
      end
      S_MIX27: begin
        cmd_o.op = DP_MIX27;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op     = DP_MUL;
        cmd_o.mul_k2 = 1'b1;
        step_d       = step_q + 2'd1;
        if (step_q == 2'd3) state_d = S_HOME;
      end
      S_HOME: begin
        cmd_o.op = DP_HOME;
        state_d  = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.probe_stop || stat_i.probe_last) begin
          if (!stat_i.out_busy) begin
            cmd_o.op = DP_RESOLVE;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = DP_STEP;
          state_d  = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `HKMT_ASSERT_NOW(a_step_not_past_last, cmd_o.op == DP_STEP, !stat_i.probe_last,
    "probe stepped past the last slot")
  `HKMT_ASSERT_NOW(a_resolve_out_free, cmd_o.op == DP_RESOLVE, !stat_i.out_busy,
    "result loaded over a pending result")
  `HKMT_ASSERT_NEXT(a_accept_starts_hash, in_valid_i && in_ready_o, state_q == S_MIX30,
    "accepted transaction did not start the hash")
  `HKMT_ASSERT_NEXT(a_mul_done_step_zero,
    (state_q == S_MUL1 || state_q == S_MUL2) && step_q == 2'd3, step_q == 2'd0,
    "multiply sequence left step counter misaligned")

endmodule
`default_nettype wire

// ----- rtl/hkmt_dp.sv -----
// Datapath for the hashed key max table: hash registers with a shared
// 32x32 multiplier, probe position, slot RAM and result register.
// Depends on hkmt_pkg and hkmt_ram.
`timescale 1ns / 1ps
`default_nettype none
module hkmt_dp
  import hkmt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [63:0] lookup_key_i,
  input  wire logic [63:0] candidate_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [63:0]      stored_max_o,
  output logic [IDX_W-1:0] slot_index_o
);

  logic [1:0]        op_q;
  logic [63:0]       key_q, cand_q;
  logic [63:0]       hv_q, hv_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       prod_q, prod_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] home_q, home_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [63:0]       max_q, max_d;
  logic [SLOT_W-1:0] idx_q, idx_d;

  logic [63:0]        mul_k, hv_fin;
  logic [31:0]        mul_a, mul_b;
  logic               we;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic               r_valid;
  logic [63:0]        r_key, r_max;
  logic               larger;

  hkmt_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  assign r_valid = rdata[ENTRY_W-1];
  assign r_key   = rdata[2*KEY_W-1:KEY_W];
  assign r_max   = rdata[KEY_W-1:0];
  assign larger  = (op_q == OP_UPDATE) && (cand_q > r_max);

  assign mul_k  = cmd_i.mul_k2 ? HASH_K2 : HASH_K1;
  assign mul_a  = (cmd_i.mul_step == 2'd1) ? hv_q[63:32] : hv_q[31:0];
  assign mul_b  = (cmd_i.mul_step == 2'd2) ? mul_k[63:32] : mul_k[31:0];
  assign hv_fin = hv_q ^ (hv_q >> 31);

  assign stat_o.clear_last = (pos_q == SLOT_W'(SLOTS - 1));
  assign stat_o.probe_stop = !r_valid || (r_key == key_q);
  assign stat_o.probe_last = (cnt_q == SLOT_W'(SLOTS - 1));
  assign stat_o.out_busy   = out_valid_q;

  always_comb begin
    hv_d        = hv_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    pos_d       = pos_q;
    home_d      = home_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    max_d       = max_q;
    idx_d       = idx_q;
    we          = 1'b0;
    wdata       = '0;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        hv_d = lookup_key_i + HASH_ADD;
      end
      DP_MIX30: begin
        hv_d = hv_q ^ (hv_q >> 30);
      end
      DP_MIX27: begin
        hv_d = hv_q ^ (hv_q >> 27);
      end
      DP_MUL: begin
        prod_d = {32'd0, mul_a} * {32'd0, mul_b};
        case (cmd_i.mul_step)
          2'd1: acc_d = prod_q;
          2'd2: acc_d = acc_q + {prod_q[31:0], 32'd0};
          2'd3: hv_d  = acc_q + {prod_q[31:0], 32'd0};
          default: acc_d = acc_q;
        endcase
      end
      DP_HOME: begin
        pos_d  = hv_fin[SLOT_W-1:0];
        home_d = hv_fin[SLOT_W-1:0];
        cnt_d  = '0;
      end
      DP_STEP: begin
        pos_d = pos_q + SLOT_W'(1);
        cnt_d = cnt_q + SLOT_W'(1);
      end
      DP_RESOLVE: begin
        out_valid_d = 1'b1;
        max_d       = '0;
        idx_d       = pos_q;
        if (!stat_o.probe_stop) begin
          status_d = ST_FULL;
          idx_d    = home_q;
        end else if (r_valid) begin
          status_d = ST_HIT;
          max_d    = larger ? cand_q : r_max;
          if (larger) begin
            we    = 1'b1;
            wdata = {1'b1, key_q, cand_q};
          end
        end else if (op_q == OP_INSERT) begin
          status_d = ST_NEW;
          we       = 1'b1;
          wdata    = {1'b1, key_q, 64'd0};
        end else begin
          status_d = ST_MISS;
        end
      end
      DP_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        pos_d = pos_q + SLOT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      op_q   <= operation_i;
      key_q  <= lookup_key_i;
      cand_q <= candidate_value_i;
    end
    hv_q     <= hv_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    home_q   <= home_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    max_q    <= max_d;
    idx_q    <= idx_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign stored_max_o = max_q;
  assign slot_index_o = IDX_W'(idx_q);

endmodule
`default_nettype wire

// ----- rtl/hashed_key_max_table_core.sv -----
// Hashed key max table: 1024-slot linear probing table of 64-bit keys with
// a running maximum per key, splitmix64 finalizer as home slot hash.
//
// Channels: in_i (operation, lookup_key, candidate_value) and out_o
// (status, stored_max, slot_index), both valid/ready; a transaction moves at
// a rising edge with valid and ready high. Operation 0 inserts, 1 raises the
// maximum, 2 reads it. Status 0 hit, 1 miss, 2 newly inserted, 3 full.
// One transaction is processed at a time. Each transaction first hashes its
// key through one shared 32x32 multiplier, then probes slots on the slot
// RAM read port, with a read state and a check state per probe; it probes
// at least one and at most 1024 slots. The next input is taken from the idle
// state that the controller enters as the result is loaded.
// After reset a clearing pass writes all 1024 slots, one per cycle, and no
// input transaction is taken until the pass ends.
// The result sits in an output register; the next input is accepted while it
// waits. If the receiver stalls, the following result holds in the probe
// stage until the output register drains.
// Depends on hkmt_pkg, hkmt_if, hkmt_ctrl and hkmt_dp.
`timescale 1ns / 1ps
`default_nettype none
module hashed_key_max_table_core
  import hkmt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hkmt_in_if.sink   in_i,
  hkmt_out_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  hkmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hkmt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (in_i.operation),
    .lookup_key_i      (in_i.lookup_key),
    .candidate_value_i (in_i.candidate_value),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .status_o          (out_o.status),
    .stored_max_o      (out_o.stored_max),
    .slot_index_o      (out_o.slot_index)
  );

  assign in_i.ready = in_ready;

endmodule
`default_nettype wire
